[rtl/sstf_pkg.sv]
package sstf_pkg;

  // Fixed field widths of the channels
  localparam int CYL_W = 16;
  localparam int SUM_W = 22;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_REQUESTS  = 64;
  localparam int DEF_CYLINDER_BITS = 16;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } sstf_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;  // accept request items
    logic scan;  // run the nearest-request scan
    logic emit;  // retire the current slot and present its result
  } sstf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_in;    // item marked last accepted this cycle
    logic scan_done;  // every pending slot read and compared
    logic out_free;   // result register can take a new item
    logic last_step;  // current slot is the final one of the batch
  } sstf_sts_t;

endpackage

[rtl/sstf_req_if.sv]
interface sstf_req_if import sstf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CYL_W-1:0] cylinder;
  logic             is_last;

  modport source (output valid, cylinder, is_last, input ready);
  modport sink   (input valid, cylinder, is_last, output ready);
endinterface

[rtl/sstf_res_if.sv]
interface sstf_res_if import sstf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CYL_W-1:0] served_cylinder;
  logic [SUM_W-1:0] running_total;
  logic             final_res;
  logic             dropped;

  modport source (output valid, served_cylinder, running_total, final_res, dropped,
                  input ready);
  modport sink   (input valid, served_cylinder, running_total, final_res, dropped,
                  output ready);
endinterface

[rtl/sstf_cfg_if.sv]
interface sstf_cfg_if import sstf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CYL_W-1:0] start_cylinder;

  modport source (output valid, start_cylinder, input ready);
  modport sink   (input valid, start_cylinder, output ready);
endinterface

[rtl/shortest_seek_first_scheduler.sv]
// Channel   Dir  Handshake     Payload
// in_req    in   valid/ready   cylinder, is_last
// out_res   out  valid/ready   served_cylinder, running_total, final_res, dropped
// cfg_wr    in   valid/ready   start_cylinder
//
// Requests load at one item a cycle; the item marked last starts the schedule.
// For each served request of a batch the scan makes one read a cycle over the
// pending slots of the request table, compares the last slot read, leaves the
// scan and then settles the slot.
// Reset (rst_n, synchronous) empties the batch and clears start_cylinder.
// No requests are taken while a batch is served; a stalled result holds the
// schedule in its emit step.
module shortest_seek_first_scheduler import sstf_pkg::*; #(
  parameter int MAX_REQUESTS  = DEF_MAX_REQUESTS,
  parameter int CYLINDER_BITS = DEF_CYLINDER_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  sstf_req_if.sink   in_req,
  sstf_res_if.source out_res,
  sstf_cfg_if.sink   cfg_wr
);

  sstf_cmd_t cmd;
  sstf_sts_t sts;

  sstf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  sstf_dp #(
    .MAX_REQUESTS  (MAX_REQUESTS),
    .CYLINDER_BITS (CYLINDER_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

endmodule

[rtl/sstf_ram.sv]
module sstf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/sstf_ctrl.sv]
module sstf_ctrl import sstf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  sstf_sts_t sts,
  output sstf_cmd_t cmd
);

  sstf_state_t state_r, state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (sts.last_in) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.last_step ? ST_LOAD : ST_SCAN;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_LOAD: cmd.take = 1'b1;
      ST_SCAN: cmd.scan = 1'b1;
      ST_EMIT: cmd.emit = sts.out_free;
      default: cmd = '0;
    endcase
  end

  // Last result of a batch returns to loading
  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && cmd.emit && sts.last_step) |=> (state_r == ST_LOAD))
    else $error("controller did not return to loading after the last result");

endmodule

[rtl/sstf_dp.sv]
module sstf_dp import sstf_pkg::*; #(
  parameter int MAX_REQUESTS  = DEF_MAX_REQUESTS,
  parameter int CYLINDER_BITS = DEF_CYLINDER_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  sstf_cmd_t   cmd,
  output sstf_sts_t   sts,
  sstf_req_if.sink    in_req,
  sstf_res_if.source  out_res,
  sstf_cfg_if.sink    cfg_wr
);

  localparam int CW = (CYLINDER_BITS < CYL_W) ? CYLINDER_BITS : CYL_W;
  localparam int IW = $clog2(MAX_REQUESTS);
  localparam int NW = $clog2(MAX_REQUESTS + 1);
  localparam logic [NW-1:0] N_MAX = NW'(MAX_REQUESTS);

  // Control state
  logic [CYL_W-1:0] start_r;
  logic [NW-1:0]    count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IW-1:0]    i_r, i_nxt;
  logic [NW-1:0]    j_r, j_nxt;
  logic             pend_r, pend_nxt;
  logic [IW-1:0]    pend_addr_r, pend_addr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CW-1:0]    head_r, head_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  // Payload
  logic [CW-1:0]    cur_r, cur_nxt;
  logic [CW-1:0]    best_r, best_nxt;
  logic [CYL_W-1:0] out_cyl_r, out_cyl_nxt;
  logic [SUM_W-1:0] out_total_r, out_total_nxt;
  logic             out_final_r, out_final_nxt;
  logic             out_drop_r, out_drop_nxt;

  // Memory port
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [CW-1:0] mem_rdata;

  logic             in_fire;
  logic [CW-1:0]    rd_dist;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat;
  logic             last_step;

  sstf_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_REQUESTS)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Handshakes
  assign in_req.ready = cmd.take;
  assign cfg_wr.ready = 1'b1;
  assign in_fire      = in_req.valid && cmd.take;

  // Distance of the slot just read from the head
  assign rd_dist = (mem_rdata >= head_r) ? (mem_rdata - head_r) : (head_r - mem_rdata);

  // Saturating travel sum for the current slot
  assign sum_wide  = {1'b0, sum_r} + (SUM_W + 1)'(best_r);
  assign sum_sat   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
  assign last_step = ((NW'(i_r) + NW'(1)) == count_r);
  assign mem_raddr = j_r[IW-1:0];

  always_comb begin
    sts.last_in   = in_fire && in_req.is_last;
    sts.scan_done = !pend_r && (j_r == count_r);
    sts.out_free  = !out_valid_r || out_res.ready;
    sts.last_step = last_step;
  end

  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    head_nxt      = head_r;
    sum_nxt       = sum_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    out_cyl_nxt   = out_cyl_r;
    out_total_nxt = out_total_r;
    out_final_nxt = out_final_r;
    out_drop_nxt  = out_drop_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    mem_we        = 1'b0;
    mem_waddr     = count_r[IW-1:0];
    mem_wdata     = in_req.cylinder[CW-1:0];

    // Load: store the request, or drop it when the table is full; the last item sets the head to the start cylinder
    if (in_fire) begin
      if (count_r < N_MAX) begin
        mem_we    = 1'b1;
        count_nxt = count_r + NW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
      if (in_req.is_last) begin
        head_nxt = start_r[CW-1:0];
        sum_nxt  = '0;
        i_nxt    = '0;
        j_nxt    = '0;
      end
    end

    // Scan: issue one read a cycle and compare each slot once its registered read data returns
    if (cmd.scan) begin
      if (j_r < count_r) begin
        pend_nxt      = 1'b1;
        pend_addr_nxt = j_r[IW-1:0];
        j_nxt         = j_r + NW'(1);
      end
      if (pend_r) begin
        if (pend_addr_r == i_r) begin
          cur_nxt  = mem_rdata;
          best_nxt = rd_dist;
        end else if (rd_dist < best_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r;
          mem_wdata = cur_r;
          cur_nxt   = mem_rdata;
          best_nxt  = rd_dist;
        end
      end
    end

    // Emit: settle slot i, move the head and present the result
    if (cmd.emit) begin
      mem_we        = 1'b1;
      mem_waddr     = i_r;
      mem_wdata     = cur_r;
      head_nxt      = cur_r;
      sum_nxt       = sum_sat;
      out_cyl_nxt   = CYL_W'(cur_r);
      out_total_nxt = sum_sat;
      out_final_nxt = last_step;
      out_drop_nxt  = ovf_r;
      out_valid_nxt = 1'b1;
      i_nxt         = i_r + IW'(1);
      j_nxt         = NW'(i_r) + NW'(1);
      if (last_step) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
        sum_nxt   = '0;
        i_nxt     = '0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      pend_r      <= 1'b0;
      pend_addr_r <= '0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      sum_r       <= '0;
    end else begin
      if (cfg_wr.valid) begin
        start_r <= cfg_wr.start_cylinder;
      end
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      pend_r      <= pend_nxt;
      pend_addr_r <= pend_addr_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      sum_r       <= sum_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    best_r      <= best_nxt;
    out_cyl_r   <= out_cyl_nxt;
    out_total_r <= out_total_nxt;
    out_final_r <= out_final_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.served_cylinder = out_cyl_r;
  assign out_res.running_total   = out_total_r;
  assign out_res.final_res       = out_final_r;
  assign out_res.dropped         = out_drop_r;

  // A read in flight lies within the pending part of the table
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ((NW'(pend_addr_r) >= NW'(i_r)) && (NW'(pend_addr_r) < count_r)))
    else $error("scan read outside the pending slots");

  // A swap during the scan never overwrites the slot being settled
  a_swap_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan && mem_we) |-> (mem_waddr != i_r))
    else $error("scan swap hit the current slot");

  // Emit only into a free result register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_res.ready))
    else $error("result overwritten before it was taken");

  // Fill count never passes the table depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= N_MAX)
    else $error("request count beyond table depth");

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import sstf_pkg::*;

  localparam int MAX_REQ     = DEF_MAX_REQUESTS;
  localparam int CYL_BITS    = DEF_CYLINDER_BITS;
  localparam int ITEM_TARGET = 370;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PRINT_CAP   = 40;

  localparam logic [SUM_W-1:0] SUM_SAT  = '1;
  localparam logic [CYL_W-1:0] CYL_MASK = {CYL_BITS{1'b1}};

  typedef struct packed {
    logic [CYL_W-1:0] served;
    logic [SUM_W-1:0] total;
    logic             final_res;
    logic             dropped;
  } seek_result_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  // One line of stimulus: a request item or a start-cylinder write
  typedef struct packed {
    row_kind_t        kind;
    logic [CYL_W-1:0] value;
    logic             last;
    logic             typed;
    seek_result_t     want;
  } stim_row_t;

  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY,
    STALL_BEAT
  } stall_mode_t;

  typedef enum int {
    CYL_SPREAD,
    CYL_CLUSTER,
    CYL_EDGES
  } cyl_style_t;

  logic clk;
  logic rst_n;

  sstf_req_if req_if ();
  sstf_res_if res_if ();
  sstf_cfg_if cfg_if ();

  shortest_seek_first_scheduler u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_res (res_if),
    .cfg_wr  (cfg_if)
  );

  stim_row_t        request_feed[$];
  stim_row_t        rows[$];
  stim_row_t        cur_req;
  seek_result_t     seek_results_due[$];
  logic [CYL_W-1:0] batch_cyls[$];
  logic             batch_dropped = 1'b0;
  logic [CYL_W-1:0] start_cyl = '0;

  int          errors      = 0;
  int          cycle_count = 0;
  int          burst_left  = 1;
  int          gap_left    = 0;
  int          mode_left   = 0;
  stall_mode_t stall_mode  = STALL_NONE;

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int seek_gap(input logic [CYL_W-1:0] a, input logic [CYL_W-1:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  function automatic stim_row_t req_row(input logic [CYL_W-1:0] cyl, input logic last);
    stim_row_t r;
    r = '0;
    r.kind  = ROW_REQ;
    r.value = cyl;
    r.last  = last;
    return r;
  endfunction

  // Single-request batch whose result is plain to see
  function automatic stim_row_t checked_row(input logic [CYL_W-1:0] cyl,
                                            input logic [CYL_W-1:0] served,
                                            input logic [SUM_W-1:0] total);
    stim_row_t r;
    r = req_row(cyl, 1'b1);
    r.typed          = 1'b1;
    r.want.served    = served;
    r.want.total     = total;
    r.want.final_res = 1'b1;
    r.want.dropped   = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CYL_W-1:0] value);
    stim_row_t r;
    r = '0;
    r.kind  = ROW_CFG;
    r.value = value;
    return r;
  endfunction

  function automatic logic [CYL_W-1:0] pick_cylinder(input cyl_style_t style,
                                                     input logic [CYL_W-1:0] base);
    case (style)
      CYL_CLUSTER: return base + CYL_W'($urandom_range(0, 16)) - CYL_W'(8);
      CYL_EDGES: begin
        if ($urandom_range(0, 1) == 1) return CYL_W'($urandom_range(0, 3));
        return ~CYL_W'($urandom_range(0, 3));
      end
      default: return CYL_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("mismatch: %s got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
  endtask

  // Serve the closed batch nearest-first; an earlier slot wins a tie
  task automatic plan_seek_order(input logic [CYL_W-1:0] head_start);
    logic [CYL_W-1:0] tab[$];
    logic [CYL_W-1:0] head;
    logic [CYL_W-1:0] swap;
    logic [SUM_W-1:0] sum;
    seek_result_t     res;
    int               n, i, j, best, gap_now, acc;
    bit               have;
    tab  = batch_cyls;
    n    = tab.size();
    head = head_start & CYL_MASK;
    sum  = '0;
    for (i = 0; i < n; i++) begin
      have = 1'b0;
      best = 0;
      for (j = i; j < n; j++) begin
        gap_now = seek_gap(tab[j], head);
        if (!have || gap_now < best) begin
          have   = 1'b1;
          best   = gap_now;
          swap   = tab[j];
          tab[j] = tab[i];
          tab[i] = swap;
        end
      end
      acc  = int'(sum) + seek_gap(head, tab[i]);
      sum  = (acc > int'(SUM_SAT)) ? SUM_SAT : SUM_W'(acc);
      head = tab[i];
      res.served    = head;
      res.total     = sum;
      res.final_res = (i == n - 1);
      res.dropped   = batch_dropped;
      seek_results_due.push_back(res);
    end
  endtask

  // Hold until every request is taken and every result has come back
  task automatic wait_drained();
    while (request_feed.size() != 0 || req_if.valid || seek_results_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_start(input logic [CYL_W-1:0] value);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_if.valid          <= 1'b1;
    cfg_if.start_cylinder <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    start_cyl = value;
  endtask

  // Feed request items in bursts and predict as each item is taken
  always @(posedge clk) begin
    if (req_if.valid && req_if.ready) begin
      if (batch_cyls.size() < MAX_REQ)
        batch_cyls.push_back(cur_req.value & CYL_MASK);
      else
        batch_dropped = 1'b1;
      if (cur_req.last) begin
        if (cur_req.typed)
          seek_results_due.push_back(cur_req.want);
        else
          plan_seek_order(start_cyl);
        batch_cyls.delete();
        batch_dropped = 1'b0;
      end
    end
    if (!req_if.valid || req_if.ready) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        req_if.valid <= 1'b0;
      end else if (request_feed.size() > 0) begin
        cur_req = request_feed.pop_front();
        req_if.valid    <= 1'b1;
        req_if.cylinder <= cur_req.value;
        req_if.is_last  <= cur_req.last;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 12);
          gap_left   = $urandom_range(1, 6);
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Stall the result channel in a stall mode picked at random
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(50, 300);
    end else begin
      mode_left = mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  res_if.ready <= 1'b1;
      STALL_COIN:  res_if.ready <= ($urandom_range(0, 1) == 1);
      STALL_HEAVY: res_if.ready <= ($urandom_range(0, 3) == 0);
      default:     res_if.ready <= ((mode_left % 7) < 4);
    endcase
  end

  // Compare each result item with the oldest one due
  always @(posedge clk) begin
    seek_result_t want;
    if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (seek_results_due.size() == 0) begin
        report_mismatch("result with nothing due, served_cylinder",
                        res_if.served_cylinder, -1);
      end else begin
        want = seek_results_due.pop_front();
        if (res_if.served_cylinder !== want.served)
          report_mismatch("served_cylinder", res_if.served_cylinder, want.served);
        if (res_if.running_total !== want.total)
          report_mismatch("running_total", res_if.running_total, want.total);
        if (res_if.final_res !== want.final_res)
          report_mismatch("final_res", res_if.final_res, want.final_res);
        if (res_if.dropped !== want.dropped)
          report_mismatch("dropped", res_if.dropped, want.dropped);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    int               sent, size, pick, k;
    bit               opening;
    logic [CYL_W-1:0] base;
    logic [CYL_W-1:0] value;
    cyl_style_t       style;

    rst_n                 = 1'b0;
    req_if.valid          = 1'b0;
    req_if.cylinder       = '0;
    req_if.is_last        = 1'b0;
    res_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.start_cylinder = '0;

    // Directed table: extremes, zero travel, ties, duplicates and reordering
    rows.push_back(checked_row(16'hFFFF, 16'hFFFF, 22'd65535));
    rows.push_back(cfg_row(16'hFFFF));
    rows.push_back(checked_row(16'h0000, 16'h0000, 22'd65535));
    rows.push_back(checked_row(16'hFFFF, 16'hFFFF, 22'd0));
    rows.push_back(cfg_row(16'd1000));
    rows.push_back(req_row(16'd1010, 1'b0));
    rows.push_back(req_row(16'd990, 1'b0));
    rows.push_back(req_row(16'd1000, 1'b0));
    rows.push_back(req_row(16'd1010, 1'b1));
    rows.push_back(cfg_row(16'd100));
    rows.push_back(req_row(16'd300, 1'b0));
    rows.push_back(req_row(16'd50, 1'b0));
    rows.push_back(req_row(16'd150, 1'b0));
    rows.push_back(req_row(16'd120, 1'b0));
    rows.push_back(req_row(16'd90, 1'b1));
    rows.push_back(cfg_row(16'h0000));
    rows.push_back(req_row(16'h8000, 1'b0));
    rows.push_back(req_row(16'h0001, 1'b0));
    rows.push_back(req_row(16'hFFFE, 1'b0));
    rows.push_back(req_row(16'h7FFF, 1'b0));
    rows.push_back(req_row(16'h0000, 1'b1));
    rows.push_back(cfg_row(16'h5555));
    rows.push_back(req_row(16'hAAAA, 1'b0));
    rows.push_back(req_row(16'h5555, 1'b1));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    sent = 0;
    foreach (rows[k]) begin
      if (rows[k].kind == ROW_CFG) begin
        write_start(rows[k].value);
      end else begin
        request_feed.push_back(rows[k]);
        sent++;
      end
    end

    // Random batches; open with one that overruns the table, last item included
    opening = 1'b1;
    while (sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (opening)
        size = MAX_REQ + 2;
      else if (pick < 70)
        size = $urandom_range(1, 8);
      else if (pick < 92)
        size = $urandom_range(9, 24);
      else if (pick < 97)
        size = $urandom_range(25, MAX_REQ);
      else
        size = $urandom_range(MAX_REQ + 1, MAX_REQ + 6);
      opening = 1'b0;
      base  = CYL_W'($urandom);
      style = cyl_style_t'($urandom_range(0, 2));
      for (k = 0; k < size; k++)
        request_feed.push_back(req_row(pick_cylinder(style, base), k == size - 1));
      sent += size;

      // Move the start cylinder now and then, extremes included
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: value = '0;
          1: value = '1;
          2: value = base;
          default: value = CYL_W'($urandom);
        endcase
        write_start(value);
      end
    end

    wait_drained();
    repeat (SETTLE * 4) @(posedge clk);
    if (errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
